[sv/bbfi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bbfi_pkg
// shared types and constants for the bad block fault injector
// ----------------------------------------------------------------------------
package bbfi_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int BLK_W         = 48;
    localparam int MAX_SHIFT     = 21;

    localparam logic [3:0] OP_IO_READ   = 4'd0;
    localparam logic [3:0] OP_IO_WRITE  = 4'd1;
    localparam logic [3:0] OP_ADD_READ  = 4'd2;
    localparam logic [3:0] OP_ADD_WRITE = 4'd3;
    localparam logic [3:0] OP_REM_READ  = 4'd4;
    localparam logic [3:0] OP_REM_WRITE = 4'd5;
    localparam logic [3:0] OP_QRY_READ  = 4'd6;
    localparam logic [3:0] OP_QRY_WRITE = 4'd7;
    localparam logic [3:0] OP_CLR_READ  = 4'd8;
    localparam logic [3:0] OP_CLR_WRITE = 4'd9;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam logic [2:0] REG_FAIL_READ  = 3'd0;
    localparam logic [2:0] REG_FAIL_WRITE = 3'd1;
    localparam logic [2:0] REG_SHIFT      = 3'd2;
    localparam logic [2:0] REG_OFFSET     = 3'd3;
    localparam logic [2:0] REG_DEVICE     = 3'd4;

    typedef struct packed {
        logic [3:0]  op;
        logic [47:0] sector_or_block;
        logic [7:0]  write_fail_count;
    } in_item_t;

    typedef struct packed {
        logic [47:0] mapped_sector;
        logic        kill;
        logic [2:0]  status;
        logic        found;
        logic [8:0]  read_entries;
        logic [8:0]  write_entries;
    } out_item_t;

    // entry held in the table memory
    typedef struct packed {
        logic             is_write;
        logic [BLK_W-1:0] blk;
        logic [7:0]       cnt;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item, reset scan results
        logic scan_rd;   // issue read of scan index
        logic scan_chk;  // check the registered read data
        logic apply;     // commit table and count updates
        logic out_load;  // form result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last; // scan index at last entry
        logic need_scan; // item touches the table
        logic wr_busy;   // never set; a clear runs inside the scan
    } dp_sts_t;

endpackage : bbfi_pkg
`default_nettype wire

[sv/bad_block_fault_injector_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bad_block_fault_injector_unit
// bad block table with io kill decision and list management
// ----------------------------------------------------------------------------
// channel   handshake                payload
// in        in_valid / in_ready      in_item  (bbfi_pkg::in_item_t)
// out       out_valid / out_ready    out_item (bbfi_pkg::out_item_t)
// cfg       cfg_we                   cfg_index, cfg_data
//
// io, clear and in-range table items scan all 256 entries through the single
// table read port before the update; other items go straight to the update
// an item is taken only once the result of the one before it is formed
// reset empties both lists at once through per-entry valid bits
// a result held by out_ready does not block taking the next item; the next
// result waits until the held one is taken
// ----------------------------------------------------------------------------
module bad_block_fault_injector_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bbfi_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bbfi_pkg::out_item_t      out_item,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [47:0]         cfg_data
);

    bbfi_pkg::dp_cmd_t cmd;
    bbfi_pkg::dp_sts_t sts;

    bbfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bbfi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_item)
    );

endmodule : bad_block_fault_injector_unit
`default_nettype wire

[sv/bbfi_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bbfi_datapath
// table memory, valid bits, scan match logic, counts and result register
// ----------------------------------------------------------------------------
module bbfi_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bbfi_pkg::in_item_t in_item,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [47:0]        cfg_data,
    input  wire bbfi_pkg::dp_cmd_t  cmd,
    output bbfi_pkg::dp_sts_t       sts,
    output bbfi_pkg::out_item_t     out_item
);

    localparam int IW = bbfi_pkg::IDX_W;
    localparam int CW = bbfi_pkg::CNT_W;

    bbfi_pkg::entry_t mem [bbfi_pkg::TABLE_ENTRIES];
    bbfi_pkg::entry_t rd_data_reg;
    logic [bbfi_pkg::TABLE_ENTRIES-1:0] valid_reg;

    logic        fre_reg, fwe_reg;
    logic [4:0]  shift_reg;
    logic [47:0] offset_reg, device_reg;

    bbfi_pkg::in_item_t item_reg;
    logic [47:0] mapped_reg;
    logic [47:0] key_reg;
    logic [IW-1:0] scan_idx_reg, chk_idx_reg;
    logic        hit_w_reg, hit_r_reg, free_ok_reg;
    logic [IW-1:0] hit_r_idx_reg, free_idx_reg, hit_w_idx_reg;
    logic [7:0]  hit_r_cnt_reg;
    logic [CW-1:0] rcount_reg, wcount_reg;
    bbfi_pkg::out_item_t out_reg;

    logic [3:0]  op;
    logic        is_io, is_tbl, is_clr, sel_w, in_range;
    logic [47:0] mapped_c;
    logic [4:0]  sh;
    logic        vchk, mk;

    assign op       = item_reg.op;
    assign sel_w    = op[0];
    assign is_io    = (op == bbfi_pkg::OP_IO_READ) || (op == bbfi_pkg::OP_IO_WRITE);
    assign is_tbl   = (op >= bbfi_pkg::OP_ADD_READ) && (op <= bbfi_pkg::OP_QRY_WRITE);
    assign is_clr   = (op == bbfi_pkg::OP_CLR_READ) || (op == bbfi_pkg::OP_CLR_WRITE);
    assign in_range = !(item_reg.sector_or_block > device_reg);
    assign sh       = (shift_reg > 5'(bbfi_pkg::MAX_SHIFT)) ? 5'(bbfi_pkg::MAX_SHIFT)
                                                           : shift_reg;
    assign mapped_c = offset_reg + in_item.sector_or_block;

    assign vchk = valid_reg[chk_idx_reg];
    assign mk   = vchk && (rd_data_reg.blk == key_reg);

    assign sts.scan_last = (scan_idx_reg == IW'(bbfi_pkg::TABLE_ENTRIES - 1));
    assign sts.need_scan = is_io || is_clr || (is_tbl && in_range);
    assign sts.wr_busy   = 1'b0;
    assign out_item      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fre_reg    <= 1'b0;
            fwe_reg    <= 1'b0;
            shift_reg  <= '0;
            offset_reg <= '0;
            device_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbfi_pkg::REG_FAIL_READ:  fre_reg    <= cfg_data[0];
                bbfi_pkg::REG_FAIL_WRITE: fwe_reg    <= cfg_data[0];
                bbfi_pkg::REG_SHIFT:      shift_reg  <= cfg_data[4:0];
                bbfi_pkg::REG_OFFSET:     offset_reg <= cfg_data;
                bbfi_pkg::REG_DEVICE:     device_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // table memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
        if (cmd.apply)
        begin
            if ((op == bbfi_pkg::OP_ADD_READ || op == bbfi_pkg::OP_ADD_WRITE)
                && in_range && free_ok_reg && !hit_w_reg)
            begin
                mem[free_idx_reg] <= '{is_write: sel_w, blk: item_reg.sector_or_block,
                                       cnt: item_reg.write_fail_count};
            end
            else if (op == bbfi_pkg::OP_IO_WRITE && !(fwe_reg && hit_w_reg) && fre_reg
                     && hit_r_reg && hit_r_cnt_reg != 8'd0)
            begin
                mem[hit_r_idx_reg] <= '{is_write: 1'b0, blk: key_reg,
                                        cnt: hit_r_cnt_reg - 8'd1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rcount_reg <= '0;
            wcount_reg <= '0;
            scan_idx_reg <= '0;
            chk_idx_reg <= '0;
            hit_w_reg <= 1'b0;
            hit_r_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                item_reg     <= in_item;
                mapped_reg   <= mapped_c;
                key_reg      <= in_item.sector_or_block;
                scan_idx_reg <= '0;
                hit_w_reg    <= 1'b0;
                hit_r_reg    <= 1'b0;
                free_ok_reg  <= 1'b0;
            end
            else if (cmd.scan_rd)
            begin
                if (scan_idx_reg == '0 && is_io)
                begin
                    key_reg <= mapped_reg >> sh;
                end
                chk_idx_reg  <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end
            if (cmd.scan_chk)
            begin
                // selected-list match (write list for io): hit_w, read-list match: hit_r (is_io uses both)
                if (mk && rd_data_reg.is_write == (is_io ? 1'b1 : sel_w) && !hit_w_reg)
                begin
                    hit_w_reg     <= 1'b1;
                    hit_w_idx_reg <= chk_idx_reg;
                end
                if (mk && !rd_data_reg.is_write && !hit_r_reg)
                begin
                    hit_r_reg     <= 1'b1;
                    hit_r_idx_reg <= chk_idx_reg;
                    hit_r_cnt_reg <= rd_data_reg.cnt;
                end
                if (!vchk && !free_ok_reg)
                begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= chk_idx_reg;
                end
                // clear drops each entry of the selected list as it is scanned
                if (is_clr && vchk && rd_data_reg.is_write == sel_w)
                begin
                    valid_reg[chk_idx_reg] <= 1'b0;
                end
            end
            if (cmd.apply)
            begin
                case (op)
                    bbfi_pkg::OP_IO_WRITE:
                    begin
                        if (!(fwe_reg && hit_w_reg) && fre_reg && hit_r_reg
                            && hit_r_cnt_reg == 8'd0)
                        begin
                            valid_reg[hit_r_idx_reg] <= 1'b0;
                            if (rcount_reg != '0) rcount_reg <= rcount_reg - CW'(1);
                        end
                    end
                    bbfi_pkg::OP_ADD_READ, bbfi_pkg::OP_ADD_WRITE:
                    begin
                        if (in_range && free_ok_reg && !hit_w_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            if (sel_w) wcount_reg <= wcount_reg + CW'(1);
                            else       rcount_reg <= rcount_reg + CW'(1);
                        end
                    end
                    bbfi_pkg::OP_REM_READ, bbfi_pkg::OP_REM_WRITE:
                    begin
                        if (in_range && hit_w_reg)
                        begin
                            valid_reg[hit_w_idx_reg] <= 1'b0;
                            if (sel_w && wcount_reg != '0) wcount_reg <= wcount_reg - CW'(1);
                            if (!sel_w && rcount_reg != '0) rcount_reg <= rcount_reg - CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.out_load)
            begin
                out_reg.mapped_sector <= is_io ? mapped_reg : '0;
                out_reg.kill   <= 1'b0;
                out_reg.status <= bbfi_pkg::ST_OK;
                out_reg.found  <= 1'b0;
                out_reg.read_entries  <= 9'(rcount_reg);
                out_reg.write_entries <= 9'(wcount_reg);
                if (op == bbfi_pkg::OP_IO_READ)
                begin
                    out_reg.kill <= fre_reg && hit_r_reg;
                end
                else if (op == bbfi_pkg::OP_IO_WRITE)
                begin
                    out_reg.kill <= (fwe_reg && hit_w_reg) ||
                                    (fre_reg && hit_r_reg && hit_r_cnt_reg != 8'd0);
                end
                else if (is_tbl)
                begin
                    if (!in_range)
                        out_reg.status <= bbfi_pkg::ST_RANGE;
                    else if (op == bbfi_pkg::OP_ADD_READ || op == bbfi_pkg::OP_ADD_WRITE)
                    begin
                        if (!free_ok_reg)    out_reg.status <= bbfi_pkg::ST_FULL;
                        else if (hit_w_reg)  out_reg.status <= bbfi_pkg::ST_PRESENT;
                    end
                    else if (op == bbfi_pkg::OP_REM_READ || op == bbfi_pkg::OP_REM_WRITE)
                    begin
                        if (!hit_w_reg) out_reg.status <= bbfi_pkg::ST_NOT_FOUND;
                    end
                    else
                        out_reg.found <= hit_w_reg;
                end
            end
            if (cmd.apply && is_clr)
            begin
                if (sel_w) wcount_reg <= '0;
                else       rcount_reg <= '0;
            end
        end
    end

endmodule : bbfi_datapath
`default_nettype wire

[sv/bbfi_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bbfi_ctrl
// sequencer: accept item, scan table if needed, apply update, present result
// ----------------------------------------------------------------------------
module bbfi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bbfi_pkg::dp_cmd_t      cmd,
    input  wire bbfi_pkg::dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_LAST,
        S_APPLY,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && !sts.wr_busy;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.need_scan)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_SCAN:
            begin
                cmd.scan_chk = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_LAST;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                end
            end
            S_LAST:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : bbfi_ctrl
`default_nettype wire
